@@ hw/rtl/tis620_to_utf8_text_cleanup_defines.svh @@
// Assertion macros shared by the TIS-620 to UTF-8 cleanup checker
`ifndef TIS620_TO_UTF8_TEXT_CLEANUP_DEFINES_SVH
`define TIS620_TO_UTF8_TEXT_CLEANUP_DEFINES_SVH

// Same-cycle implication, ignored while reset is high
`define T2U_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high
`define T2U_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset
`define T2U_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/t2u_pkg.sv @@
// Types and constants of the TIS-620 to UTF-8 text cleanup block
`timescale 1ns / 1ps
`default_nettype none
package t2u_pkg;

  localparam int unsigned T2U_MAX_CAPACITY = 1024;
  localparam int unsigned CFG_W            = 11;
  localparam logic [CFG_W-1:0] CAP_RESET   = 11'd256;

  localparam int unsigned GRP_BYTES = 4;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned PTR_W     = 2;

  localparam logic [7:0] THAI_FIRST = 8'hA1;
  localparam logic [7:0] THAI_LAST  = 8'hFB;
  localparam logic [11:0] THAI_BASE = 12'hE01;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [5:0] UTF8_MASK  = 6'h3F;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_HASH   = 8'h23;
  localparam logic [7:0] CHR_NUL    = 8'h00;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_text;
  } out_word_t;

  // Bytes produced by one input word, handed to the serializer
  typedef struct packed {
    logic [GRP_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          cnt;
    logic                      last;
    logic                      bare;
  } group_t;

endpackage
`default_nettype wire

@@ hw/rtl/tis620_to_utf8_text_cleanup.sv @@
// Top level of the TIS-620 to UTF-8 text cleanup block
//
//   channel | direction | word            | handshake
//   --------+-----------+-----------------+--------------------
//   in      | sink      | in_word_t       | in_valid / in_ready
//   out     | source    | out_word_t      | out_valid / out_ready
//   cfg     | sink      | capacity, 11 b  | cfg_valid / cfg_ready
//
// Each input word yields zero to four output words: the serializer sends one
// UTF-8 byte per cycle while out_ready is high, so a Thai character after a held
// space sets the worst case of four bytes. A new input word is taken in the cycle
// the last byte of the previous group leaves. Synchronous reset clears field
// state, restores the capacity to 256 and empties the serializer. A stalled output
// holds its word and blocks further input; configuration writes are always taken.
`timescale 1ns / 1ps
`default_nettype none
module tis620_to_utf8_text_cleanup import t2u_pkg::*; #(
  parameter int unsigned MAX_CAPACITY = T2U_MAX_CAPACITY
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_word_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_word_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data
);

  logic   accept;
  logic   free;
  group_t grp;

  assign cfg_ready = 1'b1;
  assign in_ready  = free;
  assign accept    = in_valid && free;

  t2u_decode #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .accept    (accept),
    .word      (in_data),
    .grp       (grp)
  );

  t2u_serialize u_serialize (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .grp_in    (grp),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ hw/rtl/t2u_decode.sv @@
// Byte classifier, capacity check and space collapsing
`timescale 1ns / 1ps
`default_nettype none
module t2u_decode import t2u_pkg::*; #(
  parameter int unsigned MAX_CAPACITY = T2U_MAX_CAPACITY
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [CFG_W-1:0] cfg_value,
  input  wire logic             accept,
  input  wire in_word_t         word,
  output group_t                grp
);

  localparam int unsigned CW = $clog2(MAX_CAPACITY + 1);
  localparam int unsigned W  = ((CW > CFG_W) ? CW : CFG_W) + 2;

  logic [CFG_W-1:0] out_capacity;
  logic [CW-1:0]    raw_count, raw_count_next;
  logic             space_pending, space_pending_next;
  logic             stopped, stopped_next;

  logic [W-1:0]  cap_ext, cfg_ext, raw_ext;
  logic          is_ascii, is_space, is_thai, fit1, fit3;
  logic          emit_ascii, emit_thai, flush;
  logic [11:0]   code;
  logic [7:0]    thai0, thai1, thai2;

  // Effective capacity is the smaller of the register and the parameter
  always_comb begin
    cfg_ext = W'(out_capacity);
    cap_ext = (cfg_ext > W'(MAX_CAPACITY)) ? W'(MAX_CAPACITY) : cfg_ext;
    raw_ext = W'(raw_count);
    fit1    = (raw_ext + W'(1)) < cap_ext;
    fit3    = (raw_ext + W'(3)) < cap_ext;
  end

  // Classify the incoming byte
  always_comb begin
    is_ascii = (word.in_byte[7] == 1'b0) && (word.in_byte != CHR_NUL);
    is_space = (word.in_byte == CHR_SPACE) || (word.in_byte == CHR_HASH);
    is_thai  = (word.in_byte >= THAI_FIRST) && (word.in_byte <= THAI_LAST);
    code     = THAI_BASE + 12'(word.in_byte - THAI_FIRST);
    thai0    = UTF8_LEAD3;
    thai1    = UTF8_CONT | {2'b00, code[11:6] & UTF8_MASK};
    thai2    = UTF8_CONT | {2'b00, code[5:0]};
  end

  // Next state and output group
  always_comb begin
    raw_count_next     = raw_count;
    space_pending_next = space_pending;
    stopped_next       = stopped;
    emit_ascii         = 1'b0;
    emit_thai          = 1'b0;
    if (!stopped) begin
      if (word.in_byte == CHR_NUL) begin
        stopped_next = 1'b1;
      end else if (is_ascii) begin
        if (!fit1) begin
          stopped_next = 1'b1;
        end else begin
          raw_count_next = raw_count + CW'(1);
          if (is_space) begin
            space_pending_next = 1'b1;
          end else begin
            emit_ascii = 1'b1;
          end
        end
      end else if (is_thai) begin
        if (!fit3) begin
          stopped_next = 1'b1;
        end else begin
          raw_count_next = raw_count + CW'(3);
          emit_thai      = 1'b1;
        end
      end
    end
    flush = space_pending && (emit_ascii || emit_thai);
    if (flush) begin
      space_pending_next = 1'b0;
    end

    grp.bytes = '0;
    grp.cnt   = '0;
    grp.last  = word.in_last;
    grp.bare  = 1'b0;
    if (emit_ascii) begin
      if (flush) begin
        grp.bytes[0] = CHR_SPACE;
        grp.bytes[1] = word.in_byte;
        grp.cnt      = CNT_W'(2);
      end else begin
        grp.bytes[0] = word.in_byte;
        grp.cnt      = CNT_W'(1);
      end
    end else if (emit_thai) begin
      if (flush) begin
        grp.bytes[0] = CHR_SPACE;
        grp.bytes[1] = thai0;
        grp.bytes[2] = thai1;
        grp.bytes[3] = thai2;
        grp.cnt      = CNT_W'(4);
      end else begin
        grp.bytes[0] = thai0;
        grp.bytes[1] = thai1;
        grp.bytes[2] = thai2;
        grp.cnt      = CNT_W'(3);
      end
    end
    // Last word with nothing to show still closes the field
    if (word.in_last && (grp.cnt == '0)) begin
      grp.bare = 1'b1;
      grp.cnt  = CNT_W'(1);
    end
    if (word.in_last) begin
      raw_count_next     = '0;
      space_pending_next = 1'b0;
      stopped_next       = 1'b0;
    end
  end

  // Hold the capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAP_RESET;
    end else if (cfg_write) begin
      out_capacity <= cfg_value;
    end
  end

  // Advance field state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_count     <= '0;
      space_pending <= 1'b0;
      stopped       <= 1'b0;
    end else if (accept) begin
      raw_count     <= raw_count_next;
      space_pending <= space_pending_next;
      stopped       <= stopped_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/t2u_serialize.sv @@
// Result register that sends a group of up to four bytes one per cycle while out_ready is high
`timescale 1ns / 1ps
`default_nettype none
module t2u_serialize import t2u_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   load,
  input  wire group_t grp_in,
  output logic        free,
  output logic        out_valid,
  input  wire logic   out_ready,
  output out_word_t   out_data
);

  group_t           grp;
  logic [CNT_W-1:0] rem;
  logic [PTR_W-1:0] ptr;

  // Drive the current word
  always_comb begin
    out_valid            = (rem != '0);
    out_data.out_byte    = grp.bare ? CHR_NUL : grp.bytes[ptr];
    out_data.byte_valid  = !grp.bare;
    out_data.end_of_text = grp.last && (rem == CNT_W'(1));
    free = (rem == '0) || ((rem == CNT_W'(1)) && out_ready);
  end

  // Hold the group payload
  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

  // Load a new group or advance through the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      ptr <= '0;
    end else if (load) begin
      rem <= grp_in.cnt;
      ptr <= '0;
    end else if (out_valid && out_ready) begin
      rem <= rem - CNT_W'(1);
      ptr <= ptr + PTR_W'(1);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/t2u_checker.sv @@
// Port-level checker for the TIS-620 to UTF-8 cleanup block, with its bind
`timescale 1ns / 1ps
`default_nettype none
`include "tis620_to_utf8_text_cleanup_defines.svh"
module t2u_checker import t2u_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_word_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  // Stalled output word holds
  `T2U_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output word changed while stalled")
  // Reset leaves nothing queued
  `T2U_ASSERT_NEXT_ALWAYS(a_rst_empty, rst, !out_valid, "output valid right after reset")
  // A bare word only closes a field
  `T2U_ASSERT_NOW(a_bare_end, out_valid && !out_data.byte_valid, out_data.end_of_text, "bare word without end mark")
  // No new input while a stalled word waits
  `T2U_ASSERT_NOW(a_stall_block, out_valid && !out_ready, !in_ready, "input taken during output stall")
  // The last input always yields a result
  `T2U_ASSERT_NEXT(a_last_result, in_valid && in_ready && in_data.in_last, out_valid, "last word gave no result")

endmodule

bind tis620_to_utf8_text_cleanup t2u_checker u_t2u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

@@ dv/tb_tis620_to_utf8_text_cleanup.sv @@
// Self-checking testbench for the TIS-620 to UTF-8 text cleanup block
`timescale 1ns / 1ps
module tb_tis620_to_utf8_text_cleanup;
  import t2u_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned NUM_PHASES   = 8;
  localparam logic [7:0]  ASCII_LIMIT  = 8'h80;
  localparam logic [7:0]  ASCII_DEL    = 8'h7F;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_word_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;

  // Text bytes waiting to be sent, UTF-8 words waiting to arrive
  in_word_t  tis_bytes_q[$];
  out_word_t utf8_expect_q[$];

  // Shadow copy of the converter state and its capacity register
  logic [CFG_W-1:0] capacity_sh   = CAP_RESET;
  int unsigned      raw_cnt_sh    = 0;
  bit               space_held_sh = 1'b0;
  bit               stopped_sh    = 1'b0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_cnt   = 0;
  int unsigned quiet_cycles   = 0;

  always #5 clk = ~clk;

  tis620_to_utf8_text_cleanup i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Convert one accepted text byte and queue the UTF-8 words it must produce
  function automatic void convert_byte(input in_word_t w);
    out_word_t   res[$];
    logic [7:0]  glyph[$];
    logic [15:0] cp;
    int unsigned cap;
    cap = (capacity_sh > T2U_MAX_CAPACITY) ? T2U_MAX_CAPACITY : int'(capacity_sh);
    if (!stopped_sh) begin
      if (w.in_byte == CHR_NUL) begin
        stopped_sh = 1'b1;
      end else if (w.in_byte < ASCII_LIMIT) begin
        if (raw_cnt_sh + 1 >= cap) begin
          stopped_sh = 1'b1;
        end else begin
          raw_cnt_sh += 1;
          if (w.in_byte == CHR_SPACE || w.in_byte == CHR_HASH) begin
            space_held_sh = 1'b1;
          end else begin
            glyph.push_back(w.in_byte);
          end
        end
      end else if (w.in_byte >= THAI_FIRST && w.in_byte <= THAI_LAST) begin
        if (raw_cnt_sh + 3 >= cap) begin
          stopped_sh = 1'b1;
        end else begin
          raw_cnt_sh += 3;
          cp = 16'(THAI_BASE) + 16'(w.in_byte - THAI_FIRST);
          glyph.push_back(UTF8_LEAD3 | {4'h0, cp[15:12]});
          glyph.push_back(UTF8_CONT | {2'b00, cp[11:6] & UTF8_MASK});
          glyph.push_back(UTF8_CONT | {2'b00, cp[5:0] & UTF8_MASK});
        end
      end
    end
    // A held space goes out only in front of a visible character
    if (glyph.size() != 0 && space_held_sh) begin
      res.push_back('{out_byte: CHR_SPACE, byte_valid: 1'b1, end_of_text: 1'b0});
      space_held_sh = 1'b0;
    end
    foreach (glyph[i]) begin
      res.push_back('{out_byte: glyph[i], byte_valid: 1'b1, end_of_text: 1'b0});
    end
    // Close the field: mark the last word or add a bare end word, clear state
    if (w.in_last) begin
      if (res.size() == 0) begin
        res.push_back('{out_byte: CHR_NUL, byte_valid: 1'b0, end_of_text: 1'b1});
      end else begin
        res[res.size() - 1].end_of_text = 1'b1;
      end
      raw_cnt_sh    = 0;
      space_held_sh = 1'b0;
      stopped_sh    = 1'b0;
    end
    foreach (res[i]) begin
      utf8_expect_q.push_back(res[i]);
    end
  endfunction

  // Drive input words from the queue, holding each one until it is taken
  always @(posedge clk) begin : send_side
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        convert_byte(in_data);
      end
      if (!in_valid || in_ready) begin
        if (tis_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= tis_bytes_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall the output at random and check every word taken
  always @(posedge clk) begin : recv_side
    out_word_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (out_valid === 1'b1 && out_ready) begin
        if (utf8_expect_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("%0t: unexpected word: byte=%h valid=%b end=%b", $time,
                     out_data.out_byte, out_data.byte_valid, out_data.end_of_text);
          end
        end else begin
          want = utf8_expect_q.pop_front();
          if (out_data.out_byte !== want.out_byte || out_data.byte_valid !== want.byte_valid ||
              out_data.end_of_text !== want.end_of_text) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS) begin
              $display("%0t: word mismatch: expected byte=%h valid=%b end=%b, got byte=%h valid=%b end=%b",
                       $time, want.out_byte, want.byte_valid, want.end_of_text,
                       out_data.out_byte, out_data.byte_valid, out_data.end_of_text);
            end
          end
        end
      end
    end
  end

  // End the run when no handshake happens for too long
  always @(posedge clk) begin : watchdog
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
                 (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_word(input logic [7:0] b, input logic last);
    tis_bytes_q.push_back('{in_byte: b, in_last: last});
  endtask

  // Write the capacity register and update the shadow copy once it is taken
  task automatic write_capacity(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    capacity_sh = value;
    cfg_valid <= 1'b0;
  endtask

  // Wait until every word is sent and answered, then let the block settle
  task automatic wait_drained();
    do @(negedge clk);
    while (tis_bytes_q.size() != 0 || in_valid || utf8_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Queue random text fields, each closed by a word marked last
  task automatic queue_random_text(input int unsigned budget, input int unsigned max_len);
    int unsigned made;
    int unsigned len;
    int unsigned pick;
    logic [7:0]  b;
    made = 0;
    while (made < budget) begin
      if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(1, max_len);
      end else begin
        len = $urandom_range(1, (max_len < 12) ? max_len : 12);
      end
      for (int unsigned i = 0; i < len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          b = 8'($urandom_range(8'h21, 8'h7E));
        end else if (pick < 55) begin
          b = ($urandom_range(0, 1) != 0) ? CHR_SPACE : CHR_HASH;
        end else if (pick < 80) begin
          b = 8'($urandom_range(THAI_FIRST, THAI_LAST));
        end else if (pick < 88) begin
          b = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'h80, 8'hA0))
                                          : 8'($urandom_range(8'hFC, 8'hFF));
        end else if (pick < 93) begin
          b = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'h01, 8'h1F)) : ASCII_DEL;
        end else if (pick < 96) begin
          b = CHR_NUL;
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        queue_word(b, i == len - 1);
      end
      made += len;
    end
  endtask

  initial begin : stimulus
    int unsigned phase_cap    [NUM_PHASES] = '{2047, 0, 1, 2, 4, 1024, 0, 0};
    int unsigned phase_budget [NUM_PHASES] = '{50, 30, 30, 50, 50, 50, 80, 100};
    int unsigned phase_len    [NUM_PHASES] = '{12, 8, 8, 12, 12, 16, 24, 120};
    int unsigned cap;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed text at the reset capacity, no idling
    queue_word(8'h41, 1'b0);
    queue_word(CHR_SPACE, 1'b0);
    queue_word(CHR_HASH, 1'b0);
    queue_word(THAI_FIRST, 1'b0);
    queue_word(THAI_LAST, 1'b0);
    queue_word(8'h80, 1'b0);
    queue_word(8'hA0, 1'b0);
    queue_word(8'hFC, 1'b0);
    queue_word(8'hFF, 1'b0);
    queue_word(ASCII_DEL, 1'b0);
    queue_word(8'h01, 1'b0);
    queue_word(CHR_SPACE, 1'b0);
    queue_word(CHR_HASH, 1'b1);
    queue_word(8'h42, 1'b1);
    queue_word(THAI_FIRST, 1'b0);
    queue_word(CHR_NUL, 1'b0);
    queue_word(8'h41, 1'b0);
    queue_word(8'hE0, 1'b1);
    queue_word(CHR_HASH, 1'b0);
    queue_word(8'hB5, 1'b1);
    queue_word(CHR_NUL, 1'b1);
    queue_word(8'h43, 1'b0);
    queue_word(8'h90, 1'b1);
    wait_drained();

    // Random phases over several capacities and idling mixes
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      if (p == 6) begin
        cap = $urandom_range(8, 40);
      end else if (p == 7) begin
        cap = $urandom_range(60, 200);
      end else begin
        cap = phase_cap[p];
      end
      write_capacity(CFG_W'(cap));
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 70;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 70;
        end
        default: begin
          send_idle_pct  = 24;
          recv_stall_pct = 24;
        end
      endcase
      queue_random_text(phase_budget[p], phase_len[p]);
      wait_drained();
    end

    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ tis620_to_utf8_text_cleanup.f @@
+incdir+hw/rtl
hw/rtl/t2u_pkg.sv
hw/rtl/t2u_decode.sv
hw/rtl/t2u_serialize.sv
hw/rtl/tis620_to_utf8_text_cleanup.sv
hw/rtl/t2u_checker.sv
dv/tb_tis620_to_utf8_text_cleanup.sv
